// ===== src/per_warp_csr_exec_unit_assert.svh =====
// Assertion macros shared by the CSR execution unit.
`ifndef PER_WARP_CSR_EXEC_UNIT_ASSERT_SVH
`define PER_WARP_CSR_EXEC_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PWCSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PWCSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pwcsr_pkg.sv =====
// Shared types and constants of the per-warp CSR execution unit.
package pwcsr_pkg;

    localparam int CSR_ADDR_BITS = 12;
    localparam int CSR_DEPTH     = 4096;
    localparam int WARP_BITS     = 3;
    localparam int WAVE_BITS     = 9;
    localparam int RESULT_BITS   = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int Q_PTR_BITS    = 1;

    localparam logic [CSR_ADDR_BITS-1:0] RPC_CSR_ADDR = 12'h80c;
    localparam logic [WAVE_BITS-1:0]     WAVE_RESET   = 9'd32;

    // Instruction kind codes; every other code is an unknown operation.
    typedef enum logic [3:0] {
        KIND_RW        = 4'd0,
        KIND_SET       = 4'd1,
        KIND_CLEAR     = 4'd2,
        KIND_RW_IMM    = 4'd3,
        KIND_SET_IMM   = 4'd4,
        KIND_CLEAR_IMM = 4'd5,
        KIND_VSETVLI   = 4'd6,
        KIND_SETRPC    = 4'd7
    } t_kind;

    // Operation class after decode.
    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_SET     = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_VSETVLI = 3'd3,
        OP_SETRPC  = 3'd4,
        OP_UNKNOWN = 3'd5
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [WARP_BITS-1:0] warp;
        logic                 in_range;
    } t_req_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    typedef struct packed {
        logic clearing;
        logic exec;
    } t_back_sts;

endpackage

// ===== src/pwcsr_front.sv =====
// Front end: accepts and decodes CSR requests; queues those that write a result.
module pwcsr_front #(
    parameter int NUM_WARPS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [3:0]                            i_kind,
    input  logic [pwcsr_pkg::WARP_BITS-1:0]       i_warp_index,
    input  logic [pwcsr_pkg::CSR_ADDR_BITS-1:0]   i_csr_address,
    input  logic [31:0]                           i_source_one,
    input  logic [31:0]                           i_source_two,
    input  logic [4:0]                            i_immediate,
    input  logic                                  i_writes_result,
    input  pwcsr_pkg::t_q_sts                     i_q_sts,
    input  logic                                  i_clearing,
    output logic                                  o_push,
    output pwcsr_pkg::t_req_ctl                   o_ctl,
    output logic [$clog2(NUM_WARPS*pwcsr_pkg::CSR_DEPTH)-1:0] o_addr,
    output logic [DATA_WIDTH-1:0]                 o_operand
);

    localparam int ADDR_BITS = $clog2(NUM_WARPS * pwcsr_pkg::CSR_DEPTH);

    logic [32:0]                          rpc_sum;
    logic [pwcsr_pkg::CSR_ADDR_BITS-1:0]  tgt_addr;

    assign o_in_stall = i_q_sts.full || i_clearing;
    // Drop requests that write no result: accept them but queue nothing.
    assign o_push     = i_in_valid && !o_in_stall && i_writes_result;

    assign rpc_sum = {1'b0, i_source_one} + {1'b0, i_source_two};

    always_comb begin
        o_ctl.warp     = i_warp_index;
        o_ctl.in_range = ({3'b000, i_warp_index} < 6'(NUM_WARPS));
        o_ctl.op       = pwcsr_pkg::OP_UNKNOWN;
        o_operand      = '0;
        tgt_addr       = i_csr_address;
        unique case (i_kind)
            pwcsr_pkg::KIND_RW: begin
                o_ctl.op  = pwcsr_pkg::OP_WRITE;
                o_operand = DATA_WIDTH'(i_source_one);
            end
            pwcsr_pkg::KIND_SET: begin
                o_ctl.op  = pwcsr_pkg::OP_SET;
                o_operand = DATA_WIDTH'(i_source_one);
            end
            pwcsr_pkg::KIND_CLEAR: begin
                o_ctl.op  = pwcsr_pkg::OP_CLEAR;
                o_operand = DATA_WIDTH'(i_source_one);
            end
            pwcsr_pkg::KIND_RW_IMM: begin
                o_ctl.op  = pwcsr_pkg::OP_WRITE;
                o_operand = DATA_WIDTH'(i_immediate);
            end
            pwcsr_pkg::KIND_SET_IMM: begin
                o_ctl.op  = pwcsr_pkg::OP_SET;
                o_operand = DATA_WIDTH'(i_immediate);
            end
            pwcsr_pkg::KIND_CLEAR_IMM: begin
                o_ctl.op  = pwcsr_pkg::OP_CLEAR;
                o_operand = DATA_WIDTH'(i_immediate);
            end
            pwcsr_pkg::KIND_VSETVLI: begin
                o_ctl.op  = pwcsr_pkg::OP_VSETVLI;
            end
            pwcsr_pkg::KIND_SETRPC: begin
                o_ctl.op  = pwcsr_pkg::OP_SETRPC;
                o_operand = DATA_WIDTH'(rpc_sum);
                tgt_addr  = pwcsr_pkg::RPC_CSR_ADDR;
            end
            default: begin
                o_ctl.op  = pwcsr_pkg::OP_UNKNOWN;
            end
        endcase
    end

    // Flat entry index: warp times the file depth plus the CSR number.
    assign o_addr = ADDR_BITS'({i_warp_index, tgt_addr});

endmodule

// ===== src/pwcsr_fifo.sv =====
// Short request queue between the decode front end and the execute back end.
module pwcsr_fifo #(
    parameter int WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output pwcsr_pkg::t_q_sts  o_sts
);

    localparam logic [pwcsr_pkg::Q_PTR_BITS:0] FULL_COUNT =
        (pwcsr_pkg::Q_PTR_BITS+1)'(pwcsr_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0]                  r_slot [pwcsr_pkg::QUEUE_DEPTH];
    logic [pwcsr_pkg::Q_PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [pwcsr_pkg::Q_PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [pwcsr_pkg::Q_PTR_BITS:0]    r_count, n_count;

    assign o_sts.full  = (r_count == FULL_COUNT);
    assign o_sts.empty = (r_count == '0);
    assign o_data      = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + pwcsr_pkg::Q_PTR_BITS'(i_push);
        n_rd_ptr = r_rd_ptr + pwcsr_pkg::Q_PTR_BITS'(i_pop);
        n_count  = r_count + (pwcsr_pkg::Q_PTR_BITS+1)'(i_push)
                           - (pwcsr_pkg::Q_PTR_BITS+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/pwcsr_back.sv =====
// Back end: clears the CSR memory after reset and executes queued requests.
module pwcsr_back #(
    parameter int NUM_WARPS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_pop_valid,
    output logic                                  o_pop,
    input  pwcsr_pkg::t_req_ctl                   i_ctl,
    input  logic [$clog2(NUM_WARPS*pwcsr_pkg::CSR_DEPTH)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]                 i_operand,
    input  logic [pwcsr_pkg::WAVE_BITS-1:0]       i_wavefront,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [pwcsr_pkg::WARP_BITS-1:0]       o_result_warp,
    output logic [pwcsr_pkg::RESULT_BITS-1:0]     o_read_data,
    output logic                                  o_unknown_op,
    output pwcsr_pkg::t_back_sts                  o_sts
);

    localparam int DEPTH     = NUM_WARPS * pwcsr_pkg::CSR_DEPTH;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_back_state;

    t_back_state                      r_state, n_state;
    logic [ADDR_BITS-1:0]             r_clr_addr, n_clr_addr;
    logic [DATA_WIDTH-1:0]            r_csr_mem [DEPTH];
    logic [DATA_WIDTH-1:0]            r_rd_data;
    pwcsr_pkg::t_req_ctl              r_ctl;
    logic [ADDR_BITS-1:0]             r_addr;
    logic [DATA_WIDTH-1:0]            r_operand;
    logic                             r_out_valid, n_out_valid;
    logic [pwcsr_pkg::WARP_BITS-1:0]  r_out_warp;
    logic [pwcsr_pkg::RESULT_BITS-1:0] r_out_data;
    logic                             r_out_unknown;

    logic                             fire;
    logic [DATA_WIDTH-1:0]            old_val;
    logic [DATA_WIDTH-1:0]            new_val;
    logic                             upd;
    logic [DATA_WIDTH-1:0]            res_val;
    logic                             res_unknown;
    logic                             mem_we;
    logic [ADDR_BITS-1:0]             mem_waddr;
    logic [DATA_WIDTH-1:0]            mem_wdata;

    assign o_pop = (r_state == ST_IDLE) && i_pop_valid;
    assign fire  = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);

    assign o_sts.clearing = (r_state == ST_CLEAR);
    assign o_sts.exec     = (r_state == ST_EXEC);

    // Out-of-range warps read as zero and never write.
    assign old_val = r_ctl.in_range ? r_rd_data : '0;

    always_comb begin
        new_val     = r_operand;
        upd         = 1'b0;
        res_val     = old_val;
        res_unknown = 1'b0;
        unique case (r_ctl.op)
            pwcsr_pkg::OP_WRITE: begin
                upd = 1'b1;
            end
            pwcsr_pkg::OP_SET: begin
                new_val = old_val | r_operand;
                upd     = 1'b1;
            end
            pwcsr_pkg::OP_CLEAR: begin
                new_val = old_val & ~r_operand;
                upd     = 1'b1;
            end
            pwcsr_pkg::OP_VSETVLI: begin
                res_val = DATA_WIDTH'(i_wavefront);
            end
            pwcsr_pkg::OP_SETRPC: begin
                upd     = 1'b1;
                res_val = '0;
            end
            pwcsr_pkg::OP_UNKNOWN: begin
                res_val     = '0;
                res_unknown = 1'b1;
            end
            default: begin
                res_val     = '0;
                res_unknown = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = fire && upd && r_ctl.in_range;
            mem_waddr = r_addr;
            mem_wdata = new_val;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_csr_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd_data <= r_csr_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl     <= i_ctl;
            r_addr    <= i_addr;
            r_operand <= i_operand;
        end
        if (fire) begin
            r_out_warp    <= r_ctl.warp;
            r_out_data    <= pwcsr_pkg::RESULT_BITS'(res_val);
            r_out_unknown <= res_unknown;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_warp = r_out_warp;
    assign o_read_data   = r_out_data;
    assign o_unknown_op  = r_out_unknown;

endmodule

// ===== src/per_warp_csr_exec_unit.sv =====
// Top level of the per-warp CSR execution unit.
//
// Usage:
//   The request channel (i_in_valid / o_in_stall) carries one CSR instruction:
//   kind, warp, CSR number, two operands, immediate and a writes-result flag.
//   A request is taken at an edge with i_in_valid high and o_in_stall low.
//   Requests with the flag clear are taken and dropped without a result.
//   The result channel (o_out_valid / i_out_stall) returns warp, old CSR
//   value (or wavefront size, or zero) and an unknown-operation flag.
//   A taken request passes through the queue and the back end's execute state
//   into the result register. The back end reads, then writes the single-port
//   CSR memory and takes no new request until done; a 2-entry queue decouples
//   decode from execution, so requests keep flowing while a result waits.
//   While the receiver stalls, the result register holds; the back end stops,
//   the queue fills and then o_in_stall rises.
//   Reset: the back end sweeps all NUM_WARPS*4096 entries of the CSR memory
//   to zero, one entry a cycle, with o_in_stall high. The wavefront size
//   register resets to 32 and may be written at any time
//   through i_cfg_we / i_cfg_wdata while the unit is idle.
module per_warp_csr_exec_unit #(
    parameter int NUM_WARPS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pwcsr_pkg::WAVE_BITS-1:0]       i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [3:0]                            i_kind,
    input  logic [pwcsr_pkg::WARP_BITS-1:0]       i_warp_index,
    input  logic [pwcsr_pkg::CSR_ADDR_BITS-1:0]   i_csr_address,
    input  logic [31:0]                           i_source_one,
    input  logic [31:0]                           i_source_two,
    input  logic [4:0]                            i_immediate,
    input  logic                                  i_writes_result,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [pwcsr_pkg::WARP_BITS-1:0]       o_result_warp,
    output logic [pwcsr_pkg::RESULT_BITS-1:0]     o_read_data,
    output logic                                  o_unknown_op
);

`include "per_warp_csr_exec_unit_assert.svh"

    localparam int ADDR_BITS = $clog2(NUM_WARPS * pwcsr_pkg::CSR_DEPTH);
    localparam int CTL_BITS  = $bits(pwcsr_pkg::t_req_ctl);
    localparam int Q_WIDTH   = CTL_BITS + ADDR_BITS + DATA_WIDTH;

    logic [pwcsr_pkg::WAVE_BITS-1:0]  r_wavefront;

    logic                             push;
    logic                             pop;
    pwcsr_pkg::t_req_ctl              fr_ctl;
    logic [ADDR_BITS-1:0]             fr_addr;
    logic [DATA_WIDTH-1:0]            fr_operand;
    logic [Q_WIDTH-1:0]               q_head;
    pwcsr_pkg::t_q_sts                q_sts;
    pwcsr_pkg::t_req_ctl              hd_ctl;
    logic [ADDR_BITS-1:0]             hd_addr;
    logic [DATA_WIDTH-1:0]            hd_operand;
    pwcsr_pkg::t_back_sts             bk_sts;

    // Wavefront size register: written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wavefront <= pwcsr_pkg::WAVE_RESET;
        end else if (i_cfg_we) begin
            r_wavefront <= i_cfg_wdata;
        end
    end

    // Decode and classify each request.
    pwcsr_front #(
        .NUM_WARPS  (NUM_WARPS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_warp_index    (i_warp_index),
        .i_csr_address   (i_csr_address),
        .i_source_one    (i_source_one),
        .i_source_two    (i_source_two),
        .i_immediate     (i_immediate),
        .i_writes_result (i_writes_result),
        .i_q_sts         (q_sts),
        .i_clearing      (bk_sts.clearing),
        .o_push          (push),
        .o_ctl           (fr_ctl),
        .o_addr          (fr_addr),
        .o_operand       (fr_operand)
    );

    // Hold decoded requests until the back end is free.
    pwcsr_fifo #(
        .WIDTH (Q_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({fr_ctl, fr_addr, fr_operand}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_sts   (q_sts)
    );

    assign {hd_ctl, hd_addr, hd_operand} = q_head;

    // Read, modify and write the CSR entry; drive the result register.
    pwcsr_back #(
        .NUM_WARPS  (NUM_WARPS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (!q_sts.empty),
        .o_pop         (pop),
        .i_ctl         (hd_ctl),
        .i_addr        (hd_addr),
        .i_operand     (hd_operand),
        .i_wavefront   (r_wavefront),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_warp (o_result_warp),
        .o_read_data   (o_read_data),
        .o_unknown_op  (o_unknown_op),
        .o_sts         (bk_sts)
    );

    // During the clearing sweep nothing is queued and no result is shown.
    `PWCSR_ASSERT_SAME(a_clear_quiet, bk_sts.clearing, !o_out_valid && q_sts.empty, "busy while clearing")
    // Never push into a full queue.
    `PWCSR_ASSERT_SAME(a_no_overflow, q_sts.full, !push, "queue overflow")
    // A new result appears only right after an execute cycle.
    `PWCSR_ASSERT_SAME(a_result_src, $rose(o_out_valid), $past(bk_sts.exec), "result without request")
    // A popped request moves the back end to execute.
    `PWCSR_ASSERT_NEXT(a_pop_exec, pop, bk_sts.exec, "pop without execute")

endmodule

// ===== test/per_warp_csr_exec_unit_tb.sv =====
// Self-checking testbench of the per-warp CSR execution unit.
module per_warp_csr_exec_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WARPS      = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 320;
    // Covers requests that are dropped without a result.
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 400;
    // Nothing is taken during the post-reset memory sweep; the limit must outlast it.
    localparam int WATCHDOG_LIMIT = 100000;

    // Codes outside the decoded set; both must come back as unknown operations.
    localparam logic [3:0] KIND_OTHER_LO = 4'd8;
    localparam logic [3:0] KIND_OTHER_HI = 4'd15;

    // Addresses that random requests revisit often, so read-modify-write
    // sequences hit the same entry back to back.
    localparam logic [pwcsr_pkg::CSR_ADDR_BITS-1:0] HOT_ADDRS [5] =
        '{pwcsr_pkg::RPC_CSR_ADDR, 12'h000, 12'hfff, 12'h001, 12'h800};

    typedef struct packed {
        logic [3:0]                          kind;
        logic [pwcsr_pkg::WARP_BITS-1:0]     warp;
        logic [pwcsr_pkg::CSR_ADDR_BITS-1:0] addr;
        logic [31:0]                         src1;
        logic [31:0]                         src2;
        logic [4:0]                          imm;
        logic                                wr;
    } t_csr_request;

    typedef struct packed {
        logic [pwcsr_pkg::WARP_BITS-1:0]   warp;
        logic [pwcsr_pkg::RESULT_BITS-1:0] data;
        logic                              unknown;
    } t_csr_reply;

    // Shadow copy of every warp's CSR file plus the wavefront size; predicts
    // the reply of each result-writing request and checks replies in order.
    class warp_csr_mirror;
        bit [31:0]                     csr_mem [NUM_WARPS][pwcsr_pkg::CSR_DEPTH];
        bit [pwcsr_pkg::WAVE_BITS-1:0] wave_size;
        t_csr_reply                    due_replies [$];
        int                            errors;

        function new();
            wave_size = pwcsr_pkg::WAVE_RESET;
            errors    = 0;
        endfunction

        function void note_request(t_csr_request r);
            bit [31:0]  old;
            t_csr_reply exp;
            if (!r.wr) begin
                return;
            end
            old         = csr_mem[r.warp][r.addr];
            exp.warp    = r.warp;
            exp.data    = old;
            exp.unknown = 1'b0;
            case (r.kind)
                pwcsr_pkg::KIND_RW:        csr_mem[r.warp][r.addr] = r.src1;
                pwcsr_pkg::KIND_SET:       csr_mem[r.warp][r.addr] = old | r.src1;
                pwcsr_pkg::KIND_CLEAR:     csr_mem[r.warp][r.addr] = old & ~r.src1;
                pwcsr_pkg::KIND_RW_IMM:    csr_mem[r.warp][r.addr] = {27'd0, r.imm};
                pwcsr_pkg::KIND_SET_IMM:   csr_mem[r.warp][r.addr] = old | {27'd0, r.imm};
                pwcsr_pkg::KIND_CLEAR_IMM: csr_mem[r.warp][r.addr] = old & ~{27'd0, r.imm};
                pwcsr_pkg::KIND_VSETVLI: begin
                    exp.data = {{(pwcsr_pkg::RESULT_BITS-pwcsr_pkg::WAVE_BITS){1'b0}},
                                wave_size};
                end
                pwcsr_pkg::KIND_SETRPC: begin
                    csr_mem[r.warp][pwcsr_pkg::RPC_CSR_ADDR] = r.src1 + r.src2;
                    exp.data = '0;
                end
                default: begin
                    exp.data    = '0;
                    exp.unknown = 1'b1;
                end
            endcase
            due_replies.push_back(exp);
        endfunction

        function void check_reply(t_csr_reply got);
            t_csr_reply exp;
            if (due_replies.size() == 0) begin
                $error("reply with no request outstanding: warp %0d read_data %h",
                       got.warp, got.data);
                errors++;
                return;
            end
            exp = due_replies.pop_front();
            if (got.warp !== exp.warp) begin
                $error("result_warp: expected %0d, got %0d", exp.warp, got.warp);
                errors++;
            end
            if (got.data !== exp.data) begin
                $error("read_data: expected %h, got %h", exp.data, got.data);
                errors++;
            end
            if (got.unknown !== exp.unknown) begin
                $error("unknown_op: expected %0b, got %0b", exp.unknown, got.unknown);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_we        = 1'b0;
    logic [pwcsr_pkg::WAVE_BITS-1:0]     i_cfg_wdata     = pwcsr_pkg::WAVE_RESET;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_stall;
    logic [3:0]                          i_kind          = '0;
    logic [pwcsr_pkg::WARP_BITS-1:0]     i_warp_index    = '0;
    logic [pwcsr_pkg::CSR_ADDR_BITS-1:0] i_csr_address   = '0;
    logic [31:0]                         i_source_one    = '0;
    logic [31:0]                         i_source_two    = '0;
    logic [4:0]                          i_immediate     = '0;
    logic                                i_writes_result = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall     = 1'b0;
    logic [pwcsr_pkg::WARP_BITS-1:0]     o_result_warp;
    logic [pwcsr_pkg::RESULT_BITS-1:0]   o_read_data;
    logic                                o_unknown_op;

    // Pacing controls: calm turns idling off on both sides, want_hold asks the
    // receiver for one long hold-off.
    logic calm      = 1'b0;
    logic want_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;

    warp_csr_mirror mirror = new();

    per_warp_csr_exec_unit #(
        .NUM_WARPS  (NUM_WARPS),
        .DATA_WIDTH (32)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_warp_index    (i_warp_index),
        .i_csr_address   (i_csr_address),
        .i_source_one    (i_source_one),
        .i_source_two    (i_source_two),
        .i_immediate     (i_immediate),
        .i_writes_result (i_writes_result),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_warp   (o_result_warp),
        .o_read_data     (o_read_data),
        .o_unknown_op    (o_unknown_op)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: check every reply taken at this edge, then pick the stall for
    // the next one. A hold-off keeps stall high long enough for the queue to
    // fill and the request side to back up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mirror.check_reply({o_result_warp, o_read_data, o_unknown_op});
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (want_hold && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    // Watchdog: count edges at which neither channel moves anything.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("per_warp_csr_exec_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request, with a random gap first, and hold it until taken.
    // Valid stays high on return so back-to-back requests need no drop.
    task automatic send_request(input t_csr_request r);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 17) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind          <= r.kind;
        i_warp_index    <= r.warp;
        i_csr_address   <= r.addr;
        i_source_one    <= r.src1;
        i_source_two    <= r.src2;
        i_immediate     <= r.imm;
        i_writes_result <= r.wr;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        mirror.note_request(r);
    endtask

    // Drop valid, wait for every reply, then let dropped requests flush out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (mirror.due_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_csr_request rand_request();
        t_csr_request r;
        if ($urandom_range(99) < 88) begin
            r.kind = 4'($urandom_range(pwcsr_pkg::KIND_SETRPC));
        end else begin
            r.kind = 4'($urandom_range(15));
        end
        r.warp = pwcsr_pkg::WARP_BITS'($urandom_range(NUM_WARPS - 1));
        r.addr = ($urandom_range(99) < 65) ? HOT_ADDRS[$urandom_range(4)]
                                           : pwcsr_pkg::CSR_ADDR_BITS'($urandom);
        case ($urandom_range(9))
            0:       r.src1 = '0;
            1:       r.src1 = '1;
            default: r.src1 = $urandom;
        endcase
        r.src2 = ($urandom_range(9) == 0) ? '1 : 32'($urandom);
        r.imm  = 5'($urandom);
        r.wr   = ($urandom_range(99) < 88);
        return r;
    endfunction

    initial begin
        int                              counted;
        int                              phase;
        logic [pwcsr_pkg::WAVE_BITS-1:0] wave;
        t_csr_request                    r;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, wavefront size still at its reset value.
        // Full-width write, set with zero, clear with all ones.
        send_request('{pwcsr_pkg::KIND_RW, 3'd0, 12'h000, 32'hffff_ffff, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_SET, 3'd0, 12'h000, 32'd0, 32'hffff_ffff, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_CLEAR, 3'd0, 12'h000, 32'hffff_ffff, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_SET, 3'd0, 12'h000, 32'd0, 32'd0, 5'd0, 1'b1});
        // Immediate forms at the top warp and top address.
        send_request('{pwcsr_pkg::KIND_RW_IMM, 3'd7, 12'hfff, 32'hffff_ffff, 32'd0, 5'd31,
                       1'b1});
        send_request('{pwcsr_pkg::KIND_SET_IMM, 3'd7, 12'hfff, 32'd0, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_CLEAR_IMM, 3'd7, 12'hfff, 32'd0, 32'd0, 5'd31, 1'b1});
        // Set-immediate must OR in, not overwrite.
        send_request('{pwcsr_pkg::KIND_SET_IMM, 3'd3, 12'h123, 32'd0, 32'd0, 5'b10101, 1'b1});
        send_request('{pwcsr_pkg::KIND_SET_IMM, 3'd3, 12'h123, 32'd0, 32'd0, 5'b01010, 1'b1});
        send_request('{pwcsr_pkg::KIND_CLEAR, 3'd3, 12'h123, 32'd0, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_VSETVLI, 3'd5, 12'h000, 32'd0, 32'd0, 5'd0, 1'b1});
        // Program-counter sum wraps around.
        send_request('{pwcsr_pkg::KIND_SETRPC, 3'd2, 12'h000, 32'hffff_ffff, 32'd2, 5'd0,
                       1'b1});
        send_request('{pwcsr_pkg::KIND_SET, 3'd2, pwcsr_pkg::RPC_CSR_ADDR, 32'd0, 32'd0, 5'd0,
                       1'b1});
        // Unknown kinds return zero and touch nothing.
        send_request('{KIND_OTHER_LO, 3'd2, pwcsr_pkg::RPC_CSR_ADDR, 32'hffff_ffff, 32'd0,
                       5'd31, 1'b1});
        send_request('{KIND_OTHER_HI, 3'd6, 12'hfff, 32'hffff_ffff, 32'hffff_ffff, 5'd31,
                       1'b1});
        send_request('{pwcsr_pkg::KIND_SET, 3'd2, pwcsr_pkg::RPC_CSR_ADDR, 32'd0, 32'd0, 5'd0,
                       1'b1});
        // A request without a destination is dropped and changes nothing.
        send_request('{pwcsr_pkg::KIND_RW, 3'd4, 12'h555, 32'hdead_beef, 32'd0, 5'd0, 1'b0});
        send_request('{pwcsr_pkg::KIND_SETRPC, 3'd4, 12'h555, 32'h1234_5678, 32'd1, 5'd0,
                       1'b0});
        send_request('{pwcsr_pkg::KIND_RW, 3'd4, 12'h555, 32'ha5a5_a5a5, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_RW, 3'd4, 12'h555, 32'd0, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_SET, 3'd4, pwcsr_pkg::RPC_CSR_ADDR, 32'd0, 32'd0, 5'd0,
                       1'b1});
        send_request('{pwcsr_pkg::KIND_SETRPC, 3'd6, 12'h000, 32'd0, 32'd0, 5'd0, 1'b1});
        send_request('{pwcsr_pkg::KIND_CLEAR_IMM, 3'd6, pwcsr_pkg::RPC_CSR_ADDR, 32'd0, 32'd0,
                       5'd0, 1'b1});

        // Random phases, each under its own wavefront size: the lowest legal
        // value, the highest, zero, the all-ones code, then a random one.
        for (phase = 0; phase < 5; phase++) begin
            wait_drained();
            case (phase)
                0:       wave = 9'd1;
                1:       wave = 9'd256;
                2:       wave = 9'd0;
                3:       wave = 9'h1ff;
                default: wave = pwcsr_pkg::WAVE_BITS'($urandom_range(511));
            endcase
            i_cfg_wdata <= wave;
            i_cfg_we    <= 1'b1;
            @(posedge i_clk);
            i_cfg_we         <= 1'b0;
            mirror.wave_size = wave;
            // Run the second phase at full rate on both sides.
            calm <= (phase == 1);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = rand_request();
                send_request(r);
                counted++;
                // After the first 100 requests of the third phase, stall the receiver for long.
                if (phase == 2 && counted == 100) begin
                    want_hold <= 1'b1;
                end
            end
        end

        wait_drained();
        if (mirror.errors == 0) begin
            $display("per_warp_csr_exec_unit: match");
        end else begin
            $display("per_warp_csr_exec_unit: mismatch");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/pwcsr_pkg.sv
src/pwcsr_front.sv
src/pwcsr_fifo.sv
src/pwcsr_back.sv
src/per_warp_csr_exec_unit.sv
test/per_warp_csr_exec_unit_tb.sv
